// ===== rtl/core/pnch_pkg.sv =====
// Shared constants, codes and types of the path node coverage histogram block.
`timescale 1ns / 1ps
`default_nettype none
package pnch_pkg;

    localparam int DATA_W      = 32;
    localparam int MODE_W      = 2;
    localparam int QUERY_W     = 16;
    localparam int READ_W      = 16;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    // Input item modes.
    localparam logic [MODE_W-1:0] MODE_LEAF  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_START = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BIN   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_COV   = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_NODE_COUNT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DELTA_MODE = 1'd1;

    typedef struct packed {
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic              sub;
    } alu_req_t;

    typedef struct packed {
        logic [DATA_W-1:0] sum;
        logic              borrow;
    } alu_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/core/pnch_in_if.sv =====
// Input channel of the path node coverage histogram block.
`timescale 1ns / 1ps
`default_nettype none
interface pnch_in_if;
    logic                                valid;
    logic                                ready;
    logic [pnch_pkg::MODE_W-1:0]         mode;
    logic signed [pnch_pkg::DATA_W-1:0]  leaf;
    logic [pnch_pkg::QUERY_W-1:0]        query_index;

    modport source (output valid, output mode, output leaf, output query_index, input ready);
    modport sink (input valid, input mode, input leaf, input query_index, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/pnch_out_if.sv =====
// Result channel of the path node coverage histogram block.
`timescale 1ns / 1ps
`default_nettype none
interface pnch_out_if;
    logic                         valid;
    logic                         ready;
    logic [pnch_pkg::READ_W-1:0]  read_value;
    logic                         overflow;

    modport source (output valid, output read_value, output overflow, input ready);
    modport sink (input valid, input read_value, input overflow, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/pnch_ram.sv =====
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module pnch_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/pnch_alu.sv =====
// Shared add/subtract unit used by the arithmetic steps of the item sequence; the clearing pass counts on its own.
`timescale 1ns / 1ps
`default_nettype none
module pnch_alu (
    input  wire pnch_pkg::alu_req_t req,
    output pnch_pkg::alu_rsp_t      rsp
);
    import pnch_pkg::*;

    logic [DATA_W:0] full;

    // A subtract is a plus the inverted b plus one; no carry out means a borrow.
    assign full = {1'b0, req.a} + {1'b0, (req.sub ? ~req.b : req.b)}
                  + {{DATA_W{1'b0}}, req.sub};
    assign rsp.sum    = full[DATA_W-1:0];
    assign rsp.borrow = req.sub & ~full[DATA_W];

endmodule
`default_nettype wire

// ===== rtl/core/per_path_node_coverage_histogram_unit.sv =====
// Top level of the path node coverage histogram block: sequencer, stores and result register.
//
// Each item is processed by a small sequencer that drives one shared 32-bit add/subtract
// unit and two single-write, single-read RAMs (per-node tag and coverage, and the coverage
// histogram); the block takes no new item while one is in progress. After reset a clearing
// pass writes zero to every RAM entry, one entry per cycle; configuration writes are taken
// during that pass but no item is. A counted leaf goes through the delta accumulate step in
// delta mode, the magnitude and range steps and the node read-modify-write, then the old bin
// decrement (or, for a newly covered node, the covered count increment) and the new bin
// increment, all through the single adder; a leaf may be dropped in idle, after the range
// step or after the node check. A read ends in the result state, which loads the result
// register; that register holds the result until it is transferred while the next item is
// already being taken, and a read that finds it still full waits for that transfer.
`timescale 1ns / 1ps
`default_nettype none
module per_path_node_coverage_histogram_unit #(
    parameter int MAX_NODES = 65535,
    parameter int MAX_PATHS = 1023
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [pnch_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [pnch_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    pnch_in_if.sink                               in_ch,
    pnch_out_if.source                            out_ch
);
    import pnch_pkg::*;

    // Node ids come from a 16-bit register or query, so storage never exceeds 65536 nodes.
    localparam int NODE_LIM   = (MAX_NODES < 65535) ? MAX_NODES : 65535;
    localparam int NODE_DEPTH = NODE_LIM + 1;
    localparam int ADDR_W     = $clog2(NODE_DEPTH);
    localparam int HIST_DEPTH = MAX_PATHS + 1;
    localparam int PATH_W     = $clog2(HIST_DEPTH);
    localparam int HCNT_W     = $clog2(NODE_DEPTH);
    localparam int NODE_W     = 2 * PATH_W;
    localparam int CLR_DEPTH  = (NODE_DEPTH > HIST_DEPTH) ? NODE_DEPTH : HIST_DEPTH;
    localparam int CLR_W      = $clog2(CLR_DEPTH);

    localparam logic [4:0] S_CLR    = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_ACC    = 5'd2;
    localparam logic [4:0] S_MAG    = 5'd3;
    localparam logic [4:0] S_RANGE  = 5'd4;
    localparam logic [4:0] S_NCHK   = 5'd5;
    localparam logic [4:0] S_NUPD   = 5'd6;
    localparam logic [4:0] S_COVINC = 5'd7;
    localparam logic [4:0] S_HDEC   = 5'd8;
    localparam logic [4:0] S_HINC   = 5'd9;
    localparam logic [4:0] S_START  = 5'd10;
    localparam logic [4:0] S_BIN0   = 5'd11;
    localparam logic [4:0] S_HQ     = 5'd12;
    localparam logic [4:0] S_HQD    = 5'd13;
    localparam logic [4:0] S_NQ     = 5'd14;
    localparam logic [4:0] S_NQD    = 5'd15;
    localparam logic [4:0] S_RES    = 5'd16;

    logic [4:0]            state_reg, state_next;
    logic [CLR_W-1:0]      clr_reg, clr_next;
    logic [CFG_DATA_W-1:0] node_count_reg;
    logic                  delta_reg;
    logic [DATA_W-1:0]     val_reg, val_next;
    logic [DATA_W-1:0]     sum_reg, sum_next;
    logic [QUERY_W-1:0]    q_reg, q_next;
    logic [PATH_W-1:0]     path_reg, path_next;
    logic [PATH_W-1:0]     cov_reg, cov_next;
    logic [PATH_W-1:0]     cinc_reg, cinc_next;
    logic [HCNT_W-1:0]     covered_reg, covered_next;
    logic                  ovf_reg, ovf_next;
    logic [READ_W-1:0]     res_reg, res_next;
    logic                  out_valid_reg, out_valid_next;
    logic [READ_W-1:0]     out_value_reg, out_value_next;
    logic                  out_ovf_reg, out_ovf_next;

    alu_req_t alu_req;
    alu_rsp_t alu_rsp;

    logic              node_we, node_re;
    logic [ADDR_W-1:0] node_waddr, node_raddr;
    logic [NODE_W-1:0] node_wdata, node_rdata;
    logic              hist_we, hist_re;
    logic [PATH_W-1:0] hist_waddr, hist_raddr;
    logic [HCNT_W-1:0] hist_wdata, hist_rdata;

    logic [PATH_W-1:0] rd_tag, rd_cov;
    logic              in_range;

    pnch_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    pnch_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODE_DEPTH)
    ) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .re    (node_re),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    pnch_ram #(
        .WIDTH (HCNT_W),
        .DEPTH (HIST_DEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .re    (hist_re),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    assign rd_tag = node_rdata[NODE_W-1:PATH_W];
    assign rd_cov = node_rdata[PATH_W-1:0];

    // In the range step the adder computes node_count minus the magnitude.
    assign in_range = (val_reg != '0) && !alu_rsp.borrow
                      && (val_reg <= DATA_W'(NODE_LIM));

    assign in_ch.ready       = (state_reg == S_IDLE);
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.read_value = out_value_reg;
    assign out_ch.overflow   = out_ovf_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        val_next       = val_reg;
        sum_next       = sum_reg;
        q_next         = q_reg;
        path_next      = path_reg;
        cov_next       = cov_reg;
        cinc_next      = cinc_reg;
        covered_next   = covered_reg;
        ovf_next       = ovf_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_ovf_next   = out_ovf_reg;

        alu_req.a   = '0;
        alu_req.b   = '0;
        alu_req.sub = 1'b0;

        node_we    = 1'b0;
        node_waddr = val_reg[ADDR_W-1:0];
        node_wdata = '0;
        node_re    = 1'b0;
        node_raddr = val_reg[ADDR_W-1:0];
        hist_we    = 1'b0;
        hist_waddr = cov_reg;
        hist_wdata = '0;
        hist_re    = 1'b0;
        hist_raddr = cov_reg;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLR:
            begin
                node_we    = (clr_reg <= CLR_W'(NODE_DEPTH - 1));
                node_waddr = clr_reg[ADDR_W-1:0];
                hist_we    = (clr_reg <= CLR_W'(HIST_DEPTH - 1));
                hist_waddr = clr_reg[PATH_W-1:0];
                if (clr_reg == CLR_W'(CLR_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    val_next = in_ch.leaf;
                    q_next   = in_ch.query_index;
                    res_next = '0;
                    case (in_ch.mode)
                        MODE_LEAF:
                        begin
                            if (path_reg == '0 || ovf_reg)
                            begin
                                state_next = S_IDLE;
                            end
                            else if (delta_reg)
                            begin
                                state_next = S_ACC;
                            end
                            else
                            begin
                                state_next = S_MAG;
                            end
                        end
                        MODE_START:
                        begin
                            state_next = S_START;
                        end
                        MODE_BIN:
                        begin
                            if (in_ch.query_index == '0)
                            begin
                                state_next = S_BIN0;
                            end
                            else if (in_ch.query_index <= QUERY_W'(MAX_PATHS))
                            begin
                                state_next = S_HQ;
                            end
                            else
                            begin
                                state_next = S_RES;
                            end
                        end
                        MODE_COV:
                        begin
                            if (in_ch.query_index != '0
                                && in_ch.query_index <= QUERY_W'(NODE_LIM))
                            begin
                                state_next = S_NQ;
                            end
                            else
                            begin
                                state_next = S_RES;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ACC:
            begin
                alu_req.a  = sum_reg;
                alu_req.b  = val_reg;
                sum_next   = alu_rsp.sum;
                val_next   = alu_rsp.sum;
                state_next = S_MAG;
            end
            S_MAG:
            begin
                alu_req.a   = '0;
                alu_req.b   = val_reg;
                alu_req.sub = 1'b1;
                if (val_reg[DATA_W-1])
                begin
                    val_next = alu_rsp.sum;
                end
                state_next = S_RANGE;
            end
            S_RANGE:
            begin
                // The magnitude of the most negative value stays above any node count.
                alu_req.a   = DATA_W'(node_count_reg);
                alu_req.b   = val_reg;
                alu_req.sub = 1'b1;
                if (in_range)
                begin
                    node_re    = 1'b1;
                    state_next = S_NCHK;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_NCHK:
            begin
                cov_next = rd_cov;
                if (rd_tag == path_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (rd_cov >= PATH_W'(MAX_PATHS))
                begin
                    // Coverage is at its ceiling: only the tag moves on.
                    node_we    = 1'b1;
                    node_wdata = {path_reg, rd_cov};
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_NUPD;
                end
            end
            S_NUPD:
            begin
                alu_req.a  = DATA_W'(cov_reg);
                alu_req.b  = DATA_W'(1);
                node_we    = 1'b1;
                node_wdata = {path_reg, alu_rsp.sum[PATH_W-1:0]};
                cinc_next  = alu_rsp.sum[PATH_W-1:0];
                if (cov_reg == '0)
                begin
                    state_next = S_COVINC;
                end
                else
                begin
                    hist_re    = 1'b1;
                    hist_raddr = cov_reg;
                    state_next = S_HDEC;
                end
            end
            S_COVINC:
            begin
                alu_req.a    = DATA_W'(covered_reg);
                alu_req.b    = DATA_W'(1);
                covered_next = alu_rsp.sum[HCNT_W-1:0];
                hist_re      = 1'b1;
                hist_raddr   = cinc_reg;
                state_next   = S_HINC;
            end
            S_HDEC:
            begin
                alu_req.a   = DATA_W'(hist_rdata);
                alu_req.b   = DATA_W'(1);
                alu_req.sub = 1'b1;
                hist_we     = 1'b1;
                hist_waddr  = cov_reg;
                hist_wdata  = alu_rsp.sum[HCNT_W-1:0];
                hist_re     = 1'b1;
                hist_raddr  = cinc_reg;
                state_next  = S_HINC;
            end
            S_HINC:
            begin
                alu_req.a  = DATA_W'(hist_rdata);
                alu_req.b  = DATA_W'(1);
                hist_we    = 1'b1;
                hist_waddr = cinc_reg;
                hist_wdata = alu_rsp.sum[HCNT_W-1:0];
                state_next = S_IDLE;
            end
            S_START:
            begin
                alu_req.a = DATA_W'(path_reg);
                alu_req.b = DATA_W'(1);
                if (path_reg >= PATH_W'(MAX_PATHS))
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    path_next = alu_rsp.sum[PATH_W-1:0];
                end
                sum_next   = '0;
                state_next = S_IDLE;
            end
            S_BIN0:
            begin
                alu_req.a   = DATA_W'(node_count_reg);
                alu_req.b   = DATA_W'(covered_reg);
                alu_req.sub = 1'b1;
                res_next    = alu_rsp.borrow ? '0 : alu_rsp.sum[READ_W-1:0];
                state_next  = S_RES;
            end
            S_HQ:
            begin
                hist_re    = 1'b1;
                hist_raddr = q_reg[PATH_W-1:0];
                state_next = S_HQD;
            end
            S_HQD:
            begin
                res_next   = READ_W'(hist_rdata);
                state_next = S_RES;
            end
            S_NQ:
            begin
                node_re    = 1'b1;
                node_raddr = q_reg[ADDR_W-1:0];
                state_next = S_NQD;
            end
            S_NQD:
            begin
                res_next   = READ_W'(rd_cov);
                state_next = S_RES;
            end
            S_RES:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = res_reg;
                    out_ovf_next   = ovf_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            clr_reg        <= '0;
            node_count_reg <= '0;
            delta_reg      <= 1'b0;
            sum_reg        <= '0;
            path_reg       <= '0;
            covered_reg    <= '0;
            ovf_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            sum_reg       <= sum_next;
            path_reg      <= path_next;
            covered_reg   <= covered_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_NODE_COUNT: node_count_reg <= cfg_wdata;
                    REG_DELTA_MODE: delta_reg      <= cfg_wdata[0];
                    default:        delta_reg      <= delta_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg       <= val_next;
        q_reg         <= q_next;
        cov_reg       <= cov_next;
        cinc_reg      <= cinc_next;
        res_reg       <= res_next;
        out_value_reg <= out_value_next;
        out_ovf_reg   <= out_ovf_next;
    end

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLR) |-> !in_ch.ready)
        else $error("item accepted during clearing pass");

    a_covered_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        covered_reg <= HCNT_W'(NODE_LIM))
        else $error("covered node count above node limit");

    a_path_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        path_reg <= PATH_W'(MAX_PATHS))
        else $error("path number above path limit");

    a_overflow_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(ovf_reg))
        else $error("overflow flag cleared");

    a_result_from_res: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_RES))
        else $error("result loaded outside result state");

    a_hist_ports_apart: assert property (@(posedge clk) disable iff (!rst_n)
        (hist_we && hist_re) |-> (hist_waddr != hist_raddr))
        else $error("histogram read and write at one bin in one cycle");

endmodule
`default_nettype wire
